[hdl/tukey_window_generator_assert.svh]
// assertion macros used by the checker file
`ifndef TUKEY_WINDOW_GENERATOR_ASSERT_SVH
`define TUKEY_WINDOW_GENERATOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define TWG_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");

// property checked on every clock edge, reset included
`define TWG_ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: label");

`endif

[hdl/twg_pkg.sv]
`default_nettype none

package twg_pkg;

   // field and register widths
   localparam int TIME_BITS      = 24;
   localparam int CFG_BITS       = 23;
   localparam int PHASE_BITS     = 16;
   localparam int GAIN_FRAC_BITS = 15;
   localparam int OUT_BITS       = 16;

   // cordic datapath
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
   localparam int ANGLE_BITS   = 33;
   localparam logic signed [ANGLE_BITS-1:0] CORDIC_X0 = ANGLE_BITS'(652032874);
   localparam logic signed [ANGLE_BITS-1:0] Q30_ONE   = ANGLE_BITS'(1073741824);

   // rounded gain width: (v << GAIN_FRAC_BITS) >> 31
   localparam int PROD_BITS = ANGLE_BITS + GAIN_FRAC_BITS;
   localparam int GAIN_BITS = PROD_BITS - 31;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;
   localparam logic [OUT_BITS-1:0]  OUT_MAX  = '1;

   // request to result: front stage, divider cells, cordic cells, output stage
   localparam int PIPE_LATENCY = 1 + PHASE_BITS + CORDIC_STEPS + 1;

   // register indexes
   localparam logic REG_WINDOW_LENGTH = 1'b0;
   localparam logic REG_TAPER_LENGTH  = 1'b1;

   typedef enum logic [1:0] {
      SEL_RAMP,
      SEL_ZERO,
      SEL_FULL
   } gain_sel_type;

   typedef struct packed {
      gain_sel_type            sel;
      logic [CFG_BITS-1:0]     rem;
      logic [CFG_BITS-1:0]     taper;
      logic [PHASE_BITS-1:0]   quo;
   } div_stage_type;

   typedef struct packed {
      gain_sel_type                   sel;
      logic signed [ANGLE_BITS-1:0]   x;
      logic signed [ANGLE_BITS-1:0]   y;
      logic signed [ANGLE_BITS-1:0]   z;
   } cordic_stage_type;

   // atan(2^-i), 2^32 per full turn
   function automatic logic signed [ANGLE_BITS-1:0] atan_entry(input logic [STEP_BITS-1:0] idx);
      logic signed [ANGLE_BITS-1:0] a;
      case (idx)
         5'd0:  a = ANGLE_BITS'(536870912);
         5'd1:  a = ANGLE_BITS'(316933406);
         5'd2:  a = ANGLE_BITS'(167458907);
         5'd3:  a = ANGLE_BITS'(85004756);
         5'd4:  a = ANGLE_BITS'(42667331);
         5'd5:  a = ANGLE_BITS'(21354465);
         5'd6:  a = ANGLE_BITS'(10679838);
         5'd7:  a = ANGLE_BITS'(5340245);
         5'd8:  a = ANGLE_BITS'(2670163);
         5'd9:  a = ANGLE_BITS'(1335087);
         5'd10: a = ANGLE_BITS'(667544);
         5'd11: a = ANGLE_BITS'(333772);
         5'd12: a = ANGLE_BITS'(166886);
         5'd13: a = ANGLE_BITS'(83443);
         5'd14: a = ANGLE_BITS'(41722);
         5'd15: a = ANGLE_BITS'(20861);
         5'd16: a = ANGLE_BITS'(10430);
         5'd17: a = ANGLE_BITS'(5215);
         5'd18: a = ANGLE_BITS'(2608);
         5'd19: a = ANGLE_BITS'(1304);
         5'd20: a = ANGLE_BITS'(652);
         5'd21: a = ANGLE_BITS'(326);
         5'd22: a = ANGLE_BITS'(163);
         5'd23: a = ANGLE_BITS'(81);
         5'd24: a = ANGLE_BITS'(41);
         5'd25: a = ANGLE_BITS'(20);
         5'd26: a = ANGLE_BITS'(10);
         5'd27: a = ANGLE_BITS'(5);
         5'd28: a = ANGLE_BITS'(3);
         5'd29: a = ANGLE_BITS'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

[hdl/twg_div_cell.sv]
`default_nettype none

module twg_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   valid_i,
   input  wire twg_pkg::div_stage_type data_i,
   output logic                        valid_o,
   output twg_pkg::div_stage_type      data_o
);

   logic                   valid_ff;
   twg_pkg::div_stage_type data_ff;
   twg_pkg::div_stage_type data_in;
   logic [twg_pkg::CFG_BITS:0] rem_dbl;
   logic                   take;

   // one restoring step: doubled remainder against the taper length
   always_comb begin
      rem_dbl = {data_i.rem, 1'b0};
      take    = (rem_dbl >= {1'b0, data_i.taper});
      data_in = data_i;
      if (take) begin
         data_in.rem = twg_pkg::CFG_BITS'(rem_dbl - {1'b0, data_i.taper});
      end else begin
         data_in.rem = rem_dbl[twg_pkg::CFG_BITS-1:0];
      end
      data_in.quo = {data_i.quo[twg_pkg::PHASE_BITS-2:0], take};
   end

   // request valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

`default_nettype wire

[hdl/twg_cordic_cell.sv]
`default_nettype none

module twg_cordic_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [twg_pkg::STEP_BITS-1:0]     step_idx,
   input  wire logic                              valid_i,
   input  wire twg_pkg::cordic_stage_type         data_i,
   output logic                                   valid_o,
   output twg_pkg::cordic_stage_type              data_o
);

   logic                                  valid_ff;
   twg_pkg::cordic_stage_type             data_ff;
   twg_pkg::cordic_stage_type             data_in;
   logic signed [twg_pkg::ANGLE_BITS-1:0] x_shr;
   logic signed [twg_pkg::ANGLE_BITS-1:0] y_shr;
   logic signed [twg_pkg::ANGLE_BITS-1:0] angle;

   // one rotation step, direction from the sign of the residual angle
   always_comb begin
      x_shr   = data_i.x >>> step_idx;
      y_shr   = data_i.y >>> step_idx;
      angle   = twg_pkg::atan_entry(step_idx);
      data_in = data_i;
      if (!data_i.z[twg_pkg::ANGLE_BITS-1]) begin
         data_in.x = data_i.x - y_shr;
         data_in.y = data_i.y + x_shr;
         data_in.z = data_i.z - angle;
      end else begin
         data_in.x = data_i.x + y_shr;
         data_in.y = data_i.y - x_shr;
         data_in.z = data_i.z + angle;
      end
   end

   // request valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

`default_nettype wire

[hdl/tukey_window_generator.sv]
`default_nettype none
// throughput: one request per cycle, start may be high in every cycle; busy is high only in reset
// every cell is one register stage: front stage, 16 divider cells, 30 cordic cells and output stage
// reset clears both length registers to 0 and drops every request in flight
// the receiver cannot stall: rsp_valid marks each result for exactly one cycle

module tukey_window_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [twg_pkg::TIME_BITS-1:0] req_sample_time,
   output logic                                      rsp_valid,
   output logic [twg_pkg::OUT_BITS-1:0]              rsp_window_gain,
   input  wire logic                                 csr_wr_en,
   input  wire logic                                 csr_addr,
   input  wire logic [twg_pkg::CFG_BITS-1:0]         csr_wdata
);

   localparam int EXT_BITS = twg_pkg::TIME_BITS + 1;

   logic [twg_pkg::CFG_BITS-1:0] window_length_ff;
   logic [twg_pkg::CFG_BITS-1:0] taper_length_ff;

   logic                         accept;
   logic signed [EXT_BITS-1:0]   t_ext;
   logic signed [EXT_BITS-1:0]   d_ext;
   logic signed [EXT_BITS-1:0]   tp_ext;
   logic signed [EXT_BITS-1:0]   knee;
   logic signed [EXT_BITS-1:0]   fall_u;
   twg_pkg::div_stage_type       front_in;

   logic                         div_valid [0:twg_pkg::PHASE_BITS];
   twg_pkg::div_stage_type       div_data  [0:twg_pkg::PHASE_BITS];

   logic                         cor_valid [0:twg_pkg::CORDIC_STEPS];
   twg_pkg::cordic_stage_type    cor_data  [0:twg_pkg::CORDIC_STEPS];

   logic signed [twg_pkg::ANGLE_BITS:0]   v_sum;
   logic [twg_pkg::PROD_BITS-1:0]         prod;
   logic [twg_pkg::GAIN_BITS-1:0]         gain_q;
   logic [twg_pkg::OUT_BITS-1:0]          gain_in;
   logic                                  out_valid_ff;
   logic [twg_pkg::OUT_BITS-1:0]          out_gain_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= '0;
         taper_length_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            twg_pkg::REG_WINDOW_LENGTH: window_length_ff <= csr_wdata;
            twg_pkg::REG_TAPER_LENGTH:  taper_length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // region of the window and distance into the ramp
   always_comb begin
      t_ext  = EXT_BITS'(req_sample_time);
      d_ext  = EXT_BITS'(window_length_ff);
      tp_ext = EXT_BITS'(taper_length_ff);
      knee   = d_ext - tp_ext;
      fall_u = d_ext - t_ext;
      front_in.taper = taper_length_ff;
      front_in.quo   = '0;
      if (t_ext[EXT_BITS-1] || (t_ext > d_ext)) begin
         front_in.sel = twg_pkg::SEL_ZERO;
         front_in.rem = '0;
      end else if (t_ext > knee) begin
         front_in.sel = twg_pkg::SEL_RAMP;
         front_in.rem = fall_u[twg_pkg::CFG_BITS-1:0];
      end else if (t_ext >= tp_ext) begin
         front_in.sel = twg_pkg::SEL_FULL;
         front_in.rem = '0;
      end else begin
         front_in.sel = twg_pkg::SEL_RAMP;
         front_in.rem = t_ext[twg_pkg::CFG_BITS-1:0];
      end
   end

   // front stage
   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid[0] <= 1'b0;
      end else begin
         div_valid[0] <= accept;
      end
   end

   always_ff @(posedge clock) begin
      div_data[0] <= front_in;
   end

   // divider chain, one phase bit per cell
   for (genvar g = 0; g < twg_pkg::PHASE_BITS; g++) begin : g_div
      twg_div_cell u_div (
         .clock   (clock),
         .reset   (reset),
         .valid_i (div_valid[g]),
         .data_i  (div_data[g]),
         .valid_o (div_valid[g+1]),
         .data_o  (div_data[g+1])
      );
   end

   // phase to start angle: pi*p/2^PHASE_BITS - pi/2
   always_comb begin
      cor_valid[0]  = div_valid[twg_pkg::PHASE_BITS];
      cor_data[0].sel = div_data[twg_pkg::PHASE_BITS].sel;
      cor_data[0].x = twg_pkg::CORDIC_X0;
      cor_data[0].y = '0;
      cor_data[0].z = (twg_pkg::ANGLE_BITS'(div_data[twg_pkg::PHASE_BITS].quo)
                       << (31 - twg_pkg::PHASE_BITS)) - twg_pkg::Q30_ONE;
   end

   // cordic chain, one rotation per cell
   for (genvar g = 0; g < twg_pkg::CORDIC_STEPS; g++) begin : g_cor
      twg_cordic_cell u_cor (
         .clock    (clock),
         .reset    (reset),
         .step_idx (twg_pkg::STEP_BITS'(g)),
         .valid_i  (cor_valid[g]),
         .data_i   (cor_data[g]),
         .valid_o  (cor_valid[g+1]),
         .data_o   (cor_data[g+1])
      );
   end

   // (1 + sin) / 2, rounded to nearest and clamped; forced to 0 outside the window and to 1.0 on the flat top
   always_comb begin
      v_sum = (twg_pkg::ANGLE_BITS+1)'(cor_data[twg_pkg::CORDIC_STEPS].y)
              + (twg_pkg::ANGLE_BITS+1)'(twg_pkg::Q30_ONE);
      if (v_sum[twg_pkg::ANGLE_BITS]) begin
         prod = '0;
      end else begin
         prod = (twg_pkg::PROD_BITS'(v_sum[twg_pkg::ANGLE_BITS-1:0]) << twg_pkg::GAIN_FRAC_BITS)
                + twg_pkg::PROD_BITS'(twg_pkg::Q30_ONE);
      end
      gain_q = prod[twg_pkg::PROD_BITS-1:31];
      if (gain_q > twg_pkg::GAIN_ONE) begin
         gain_q = twg_pkg::GAIN_ONE;
      end
      case (cor_data[twg_pkg::CORDIC_STEPS].sel)
         twg_pkg::SEL_ZERO: gain_q = '0;
         twg_pkg::SEL_FULL: gain_q = twg_pkg::GAIN_ONE;
         default: ;
      endcase
      if (gain_q > twg_pkg::GAIN_BITS'(twg_pkg::OUT_MAX)) begin
         gain_in = twg_pkg::OUT_MAX;
      end else begin
         gain_in = twg_pkg::OUT_BITS'(gain_q);
      end
   end

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cor_valid[twg_pkg::CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      out_gain_ff <= gain_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_window_gain = out_gain_ff;

endmodule

`default_nettype wire

[hdl/twg_checker.sv]
`default_nettype none
`include "tukey_window_generator_assert.svh"

module twg_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           rsp_valid,
   input wire logic [twg_pkg::OUT_BITS-1:0]   rsp_window_gain
);

   // a gain never goes above 1.0
   `TWG_ASSERT_RST(a_gain_range, clock, reset, rsp_valid |-> (rsp_window_gain <= twg_pkg::OUT_BITS'(twg_pkg::GAIN_ONE)))

   // every result lines up with an accepted request, as far back as the pipeline is long
   `TWG_ASSERT_RST(a_rsp_latency, clock, reset, rsp_valid |-> $past(start && !busy, twg_pkg::PIPE_LATENCY))

   // reset flushes the pipeline
   `TWG_ASSERT_ALL(a_reset_flush, clock, $past(reset) |-> !rsp_valid)

endmodule

bind tukey_window_generator twg_checker u_twg_checker (.*);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int  CYCLE_LIMIT = 200000;
   localparam int  REPORT_MAX  = 10;
   localparam int  RANDOM_PHASES = 10;
   localparam int  PHASE_ITEMS   = 70;
   localparam logic [twg_pkg::CFG_BITS-1:0] LEN_MAX = '1;

   // atan(2^-i) with 2^32 per full turn
   localparam longint ATAN_TURN32 [twg_pkg::CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304,
      652, 326, 163, 81, 41,
      20, 10, 5, 3, 1
   };

   typedef struct {
      logic signed [twg_pkg::TIME_BITS-1:0] sample_time;
      logic [twg_pkg::OUT_BITS-1:0]         gain;
   } gain_expect_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic signed [twg_pkg::TIME_BITS-1:0]  req_sample_time;
   logic                                  rsp_valid;
   logic [twg_pkg::OUT_BITS-1:0]          rsp_window_gain;
   logic                                  csr_wr_en;
   logic                                  csr_addr;
   logic [twg_pkg::CFG_BITS-1:0]          csr_wdata;

   gain_expect_type              pending_gains [$];
   logic [twg_pkg::CFG_BITS-1:0] window_len;
   logic [twg_pkg::CFG_BITS-1:0] taper_len;
   int                           mismatch_count = 0;
   int                           cycle_count = 0;

   tukey_window_generator u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample_time (req_sample_time),
      .rsp_valid       (rsp_valid),
      .rsp_window_gain (rsp_window_gain),
      .csr_wr_en       (csr_wr_en),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // expected gain of the tapered cosine window at one time value
   function automatic logic [twg_pkg::OUT_BITS-1:0] tukey_gain(
      input logic signed [twg_pkg::TIME_BITS-1:0] ts,
      input logic [twg_pkg::CFG_BITS-1:0]         win,
      input logic [twg_pkg::CFG_BITS-1:0]         taper
   );
      longint t, d, tp, u, p, x, y, z, xs, ys, v, g;
      t = ts;
      d = win;
      tp = taper;
      if (t < 0 || t > d)
         return '0;
      // falling end takes precedence over the flat top
      if (t > d - tp)
         u = d - t;
      else if (t >= tp)
         return twg_pkg::OUT_BITS'(longint'(1) << twg_pkg::GAIN_FRAC_BITS);
      else
         u = t;
      if (tp == 0)
         return twg_pkg::OUT_BITS'(longint'(1) << twg_pkg::GAIN_FRAC_BITS);
      p = (u << twg_pkg::PHASE_BITS) / tp;
      // rotate from -pi/2 to get sin, gain is (1 + sin)/2
      x = 64'sd652032874;
      y = 0;
      z = (p << (31 - twg_pkg::PHASE_BITS)) - 64'sd1073741824;
      for (int i = 0; i < twg_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TURN32[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TURN32[i];
         end
      end
      v = 64'sd1073741824 + y;
      if (v < 0)
         v = 0;
      g = ((v << twg_pkg::GAIN_FRAC_BITS) + 64'sd1073741824) >> 31;
      if (g > (longint'(1) << twg_pkg::GAIN_FRAC_BITS))
         g = longint'(1) << twg_pkg::GAIN_FRAC_BITS;
      if (g > 64'sd65535)
         g = 64'sd65535;
      return twg_pkg::OUT_BITS'(g);
   endfunction

   // random time value, biased towards the window and its edges
   function automatic logic signed [twg_pkg::TIME_BITS-1:0] pick_time(
      input logic [twg_pkg::CFG_BITS-1:0] win,
      input logic [twg_pkg::CFG_BITS-1:0] taper
   );
      longint lo, hi, c;
      int     r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return twg_pkg::TIME_BITS'($urandom);
      if (r < 30) begin
         case ($urandom_range(0, 3))
            0:       c = 0;
            1:       c = longint'(win);
            2:       c = longint'(taper);
            default: c = longint'(win) - longint'(taper);
         endcase
         c = c + longint'($urandom_range(0, 6)) - 3;
      end else begin
         lo = -(longint'(win) / 16) - 2;
         hi = longint'(win) + longint'(win) / 16 + 2;
         c = lo + longint'($urandom) % (hi - lo + 1);
      end
      if (c < -64'sd8388608)
         c = -64'sd8388608;
      if (c > 64'sd8388607)
         c = 64'sd8388607;
      return twg_pkg::TIME_BITS'(c);
   endfunction

   // send one request and record its expected gain when accepted
   task automatic send_request(input logic signed [twg_pkg::TIME_BITS-1:0] ts);
      gain_expect_type e;
      @(negedge clock);
      start = 1'b1;
      req_sample_time = ts;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      e.sample_time = ts;
      e.gain = tukey_gain(ts, window_len, taper_len);
      pending_gains.push_back(e);
   endtask

   // sender idles for a number of cycles
   task automatic idle_cycles(input int n);
      @(negedge clock);
      start = 1'b0;
      req_sample_time = twg_pkg::TIME_BITS'($urandom);
      repeat (n) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_drained;
      @(negedge clock);
      start = 1'b0;
      while (pending_gains.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write, shadow copy updated on the write edge
   task automatic write_length(input logic idx, input logic [twg_pkg::CFG_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      @(posedge clock);
      if (idx == twg_pkg::REG_WINDOW_LENGTH)
         window_len = value;
      else
         taper_len = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      csr_wdata = twg_pkg::CFG_BITS'($urandom);
   endtask

   task automatic set_window(input logic [twg_pkg::CFG_BITS-1:0] win,
                             input logic [twg_pkg::CFG_BITS-1:0] taper);
      wait_drained();
      write_length(twg_pkg::REG_WINDOW_LENGTH, win);
      write_length(twg_pkg::REG_TAPER_LENGTH, taper);
   endtask

   // lengths left at their reset value of zero
   task automatic test_reset_lengths;
      send_request(24'sd0);
      send_request(-24'sd1);
      send_request(24'sd1);
      send_request(24'sh7FFFFF);
      send_request(24'sh800000);
   endtask

   // zero taper gives a rectangular window
   task automatic test_rectangular;
      set_window(23'd1000, 23'd0);
      send_request(24'sd0);
      send_request(24'sd500);
      send_request(24'sd1000);
      send_request(24'sd1001);
      send_request(-24'sd1);
   endtask

   // both ramps and the flat top
   task automatic test_tapered;
      set_window(23'd10000, 23'd2000);
      send_request(24'sd1);
      send_request(24'sd1999);
      send_request(24'sd2000);
      send_request(24'sd5000);
      send_request(24'sd8000);
      send_request(24'sd8001);
      send_request(24'sd9999);
      send_request(24'sd10000);
   endtask

   // taper longer than the window never reaches full gain
   task automatic test_long_taper;
      set_window(23'd3000, LEN_MAX);
      send_request(24'sd0);
      send_request(24'sd1500);
      send_request(24'sd2999);
   endtask

   // largest lengths and a one tick taper
   task automatic test_extreme_lengths;
      set_window(LEN_MAX, LEN_MAX);
      send_request(24'sd4194303);
      send_request(24'sh7FFFFF);
      set_window(LEN_MAX, 23'd1);
      send_request(24'sd8388606);
   endtask

   // random requests across a series of window settings
   task automatic test_random_sweep;
      logic [twg_pkg::CFG_BITS-1:0] win, taper;
      bit                           allow_idle;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         win = twg_pkg::CFG_BITS'($urandom_range(0, 8388607));
         case ($urandom_range(0, 3))
            0:       taper = '0;
            1:       taper = twg_pkg::CFG_BITS'($urandom_range(0, win / 2));
            2:       taper = twg_pkg::CFG_BITS'($urandom_range(0, 8388607));
            default: taper = win >> $urandom_range(0, 8);
         endcase
         case (phase)
            0: begin
               win = twg_pkg::CFG_BITS'($urandom_range(1000, 60000));
               taper = win / 4;
            end
            1: win = LEN_MAX;
            2: begin
               win = twg_pkg::CFG_BITS'($urandom_range(0, 255));
               taper = twg_pkg::CFG_BITS'($urandom_range(0, 255));
            end
            3: win = twg_pkg::CFG_BITS'($urandom_range(0, 3));
            4: taper = LEN_MAX;
            default: ;
         endcase
         set_window(win, taper);
         // first phase runs back to back with no gaps
         allow_idle = (phase != 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (allow_idle && $urandom_range(0, 99) < 7)
               idle_cycles(1);
            // hold off mid phase until the pipe is empty
            if (phase == 5 && k == PHASE_ITEMS / 2)
               wait_drained();
            send_request(pick_time(window_len, taper_len));
         end
      end
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      gain_expect_type e;
      if (!reset && rsp_valid) begin
         if (pending_gains.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result: gain %0d", rsp_window_gain);
         end else begin
            e = pending_gains.pop_front();
            if (rsp_window_gain !== e.gain) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("gain mismatch: time %0d win %0d taper %0d expected %0d got %0d",
                           e.sample_time, window_len, taper_len, e.gain, rsp_window_gain);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // reset, test sequence and final verdict
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_sample_time = '0;
      csr_wr_en = 1'b0;
      csr_addr = twg_pkg::REG_WINDOW_LENGTH;
      csr_wdata = '0;
      window_len = '0;
      taper_len = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_lengths();
      test_rectangular();
      test_tapered();
      test_long_taper();
      test_extreme_lengths();
      test_random_sweep();

      wait_drained();
      repeat (twg_pkg::PIPE_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_gains.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
